// ===== design/cfd_pkg.sv =====
// Shared types and constants for the caliper frame decoder.
`default_nettype none

package cfd_pkg;

	// Frame format
	localparam int unsigned FRAME_LEN  = 24;
	localparam int unsigned COUNT_SAT  = 25;
	localparam int unsigned MAG_W      = 20;
	localparam int unsigned READING_W  = MAG_W + 1;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned GAP_W      = 16;

	// Defaults
	localparam int unsigned TIME_WIDTH_DEF = 16;
	localparam logic [GAP_W-1:0] GAP_RESET = 16'h1600;

	// Depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef logic [COUNT_W-1:0] count_t;

	// One finished frame, reduced to the fields the back end needs
	typedef struct packed {
		logic             unit_inch;
		logic             sign;
		logic [MAG_W-1:0] mag;
	} frame_t;

	// Queue occupancy seen by front and back
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== design/caliper_frame_decoder_top.sv =====
// Top level of the caliper frame decoder.
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall    capture_time, data_level
//  out      output     out_valid/out_stall  reading, unit_inch
//  cfg      input      cfg_write            cfg_data (gap threshold)
//
// One edge is accepted per cycle while in_stall is low; the front end updates the frame state in
// that cycle. A finished frame is written into a two-entry queue and from there into the output
// register, which presents it with out_valid.
// Reset clears frame state, queue and output valid; the threshold returns to 0x1600.
// in_stall rises only when the queue is full; out_stall holds the output register.
`default_nettype none

module caliper_frame_decoder_top #(
	parameter int unsigned TIME_WIDTH = cfd_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_write,
	input  wire logic [cfd_pkg::GAP_W-1:0]             cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [TIME_WIDTH-1:0]                 capture_time,
	input  wire logic                                  data_level,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [cfd_pkg::READING_W-1:0]       reading,
	output logic                                       unit_inch
);
	import cfd_pkg::*;

	q_status_t q_status;
	logic      push;
	frame_t    push_frame;
	logic      pop;
	frame_t    pop_frame;

	cfd_front #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.capture_time (capture_time),
		.data_level   (data_level),
		.q_status     (q_status),
		.push         (push),
		.push_frame   (push_frame)
	);

	cfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.status     (q_status)
	);

	cfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_frame (pop_frame),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.reading   (reading),
		.unit_inch (unit_inch)
	);

endmodule

`default_nettype wire

// ===== design/cfd_front.sv =====
// Front end: edge interval, frame sync, bit shift register and frame detect.
`default_nettype none

module cfd_front #(
	parameter int unsigned TIME_WIDTH = cfd_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [cfd_pkg::GAP_W-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [TIME_WIDTH-1:0]    capture_time,
	input  wire logic                     data_level,
	input  wire cfd_pkg::q_status_t       q_status,
	output logic                          push,
	output cfd_pkg::frame_t               push_frame
);
	import cfd_pkg::*;

	localparam int unsigned CMP_W = (TIME_WIDTH > GAP_W) ? TIME_WIDTH : GAP_W;

	logic [GAP_W-1:0]      gap_q;
	logic [TIME_WIDTH-1:0] last_time_q;
	logic [FRAME_LEN-1:0]  frame_q;
	count_t                count_q;

	logic                  accept;
	logic [TIME_WIDTH-1:0] interval;
	logic                  new_frame;
	logic                  bit_in;
	logic [FRAME_LEN-1:0]  shifted;
	count_t                count_next;

	// Stall whenever the queue cannot take another frame
	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	// Classify the edge: gap starts a new frame, else shift in
	assign interval  = capture_time - last_time_q;
	assign new_frame = CMP_W'(interval) >= CMP_W'(gap_q);
	assign bit_in    = ~data_level;
	assign shifted   = {bit_in, frame_q[FRAME_LEN-1:1]};

	always_comb begin
		priority if (new_frame) begin
			count_next = count_t'(1);
		end else if (count_q < count_t'(COUNT_SAT)) begin
			count_next = count_q + count_t'(1);
		end else begin
			count_next = count_q;
		end
	end

	// Emit on the last bit of a frame
	assign push                 = accept && !new_frame && (count_next == count_t'(FRAME_LEN));
	assign push_frame.unit_inch = shifted[FRAME_LEN-1];
	assign push_frame.sign      = shifted[MAG_W];
	assign push_frame.mag       = shifted[MAG_W-1:0];

	// Hold the gap threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_write) begin
			gap_q <= cfg_data;
		end
	end

	// Advance the frame state on each accepted edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			frame_q     <= '0;
			count_q     <= '0;
		end else if (accept) begin
			last_time_q <= capture_time;
			count_q     <= count_next;
			if (new_frame) begin
				frame_q <= {bit_in, {(FRAME_LEN-1){1'b0}}};
			end else begin
				frame_q <= shifted;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/cfd_queue.sv =====
// Short frame queue between front and back ends.
`default_nettype none

module cfd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire cfd_pkg::frame_t    push_frame,
	input  wire logic               pop,
	output cfd_pkg::frame_t         pop_frame,
	output cfd_pkg::q_status_t      status
);
	import cfd_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.not_empty = (count_q != '0);
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign pop_frame        = entries_q[rd_ptr_q];

	// Write the incoming frame
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_frame;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/cfd_back.sv =====
// Back end: sign the magnitude and hold the result in the output register.
`default_nettype none

module cfd_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cfd_pkg::q_status_t                 q_status,
	input  wire cfd_pkg::frame_t                    pop_frame,
	output logic                                    pop,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [cfd_pkg::READING_W-1:0]   reading,
	output logic                                    unit_inch
);
	import cfd_pkg::*;

	logic [READING_W-1:0] mag_ext;
	logic [READING_W-1:0] value;
	logic                 valid_q;
	logic [READING_W-1:0] reading_q;
	logic                 unit_q;

	// Negate when the sign bit is set; a zero magnitude stays zero
	assign mag_ext = {1'b0, pop_frame.mag};
	assign value   = pop_frame.sign ? (~mag_ext + READING_W'(1)) : mag_ext;

	// Take a frame when the output register is free or draining
	assign pop = q_status.not_empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= q_status.not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			reading_q <= value;
			unit_q    <= pop_frame.unit_inch;
		end
	end

	assign out_valid = valid_q;
	assign reading   = $signed(reading_q);
	assign unit_inch = unit_q;

endmodule

`default_nettype wire
